>>> rtl/core/frlt_pkg.sv
// Shared types and constants for the feature run-length tracker.
`default_nettype none
package frlt_pkg;

  typedef enum logic [1:0] {
    CMD_FEATURE = 2'd0,
    CMD_EOF     = 2'd1,
    CMD_EOS     = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  localparam int unsigned KeyBits   = 62;
  localparam int unsigned CoordBits = 31;
  localparam int unsigned FrameBits = 32;
  localparam int unsigned OutBits   = 16;
  localparam int unsigned EpochBits = 8;

endpackage
`default_nettype wire

>>> rtl/core/frlt_home.sv
// Home slot unit: (x + y) mod table size; other sizes use a registered multiply, then subtract.
`default_nettype none
module frlt_home
  import frlt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             go_i,
  input  wire logic [FrameBits-1:0]             sum_i,
  output logic                                  done_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      home_o
);
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  if ((1 << IW) == TABLE_ENTRIES) begin : g_pow2
    assign done_o = go_i;
    assign home_o = sum_i[IW-1:0];
    logic unused_clk;
    assign unused_clk = clk_i ^ rst_ni;
  end else begin : g_recip
    // quotient estimate floor(sum * Mu / 2^32) is low by at most one,
    // so the remainder lands below 2 * size and one subtract finishes it
    localparam logic [31:0] Mu  = 32'((64'd1 << 32) / 64'(TABLE_ENTRIES));
    localparam logic [IW:0] Div = (IW+1)'(TABLE_ENTRIES);

    logic        mul_q, mul_d, sub_q, sub_d;
    logic [63:0] prod_q, prod_d;
    logic [IW:0] qn, rem_q, rem_d, rem_red;

    // only the low remainder bits of quotient * size are needed
    assign qn      = prod_q[FrameBits +: IW+1] * Div;
    assign rem_red = rem_q - Div;

    always_comb begin
      mul_d  = go_i && !mul_q && !sub_q;
      sub_d  = mul_q;
      prod_d = prod_q;
      rem_d  = rem_q;
      if (mul_d) begin
        prod_d = 64'(sum_i) * 64'(Mu);
      end
      if (mul_q) begin
        rem_d = sum_i[IW:0] - qn;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mul_q <= 1'b0;
        sub_q <= 1'b0;
      end else begin
        mul_q <= mul_d;
        sub_q <= sub_d;
      end
    end

    always_ff @(posedge clk_i) begin
      prod_q <= prod_d;
      rem_q  <= rem_d;
    end

    assign done_o = sub_q;
    assign home_o = (rem_q >= Div) ? rem_red[IW-1:0] : rem_q[IW-1:0];
  end

endmodule
`default_nettype wire

>>> rtl/core/feature_run_length_tracker_core.sv
// Top level of the feature run-length tracker: table memory, probe sequencer, result register.
// Steps: a feature item passes the hash (home slot), probe (up to PROBE_LIMIT table reads,
//   ending early on a key match), update and result states; other commands go straight
//   from accept to the result state.
// Throughput: one item at a time; the next item is accepted only once the result is staged
//   into the output register, and the probes read the table one slot after another.
// Reset: control state clears at once, then a clearing pass over every table entry runs
//   with input held off; the same pass follows every 256th end of sequence (epoch wrap).
`default_nettype none
module feature_run_length_tracker_core
  import frlt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned PROBE_LIMIT   = 4,
  parameter int unsigned RUN_BITS      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [30:0] feature_x, [61:31] feature_y, zero pad
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o    // [15:0] run_length, [31:16] longest_run,
                                             // [32] overflow, zero pad
);
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned PW = $clog2(PROBE_LIMIT + 1);

  typedef struct packed {
    logic                 valid;
    logic [EpochBits-1:0] epoch;
    logic [KeyBits-1:0]   key;
    logic [FrameBits-1:0] frame;
    logic [RUN_BITS-1:0]  run;
  } entry_t;

  state_e state_q, state_d;

  // item accept
  logic in_acc;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // per-sequence registers
  logic [FrameBits-1:0] frame_q, frame_d;
  logic [RUN_BITS-1:0]  best_q, best_d;
  logic [EpochBits-1:0] epoch_q, epoch_d;
  logic                 clr_after_q, clr_after_d;
  logic [IW-1:0]        clr_cnt_q, clr_cnt_d;

  // current item
  logic [KeyBits-1:0]   key_q, key_d;
  logic [FrameBits-1:0] sum_q, sum_d;
  logic [IW-1:0]        home_q, home_d;

  // probe bookkeeping
  logic [PW-1:0]        issue_q, issue_d, chk_q, chk_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [IW-1:0]        rd_slot_q, rd_slot_d;
  logic                 found_q, found_d, spare_q, spare_d;
  logic [IW-1:0]        hit_slot_q, hit_slot_d, spare_slot_q, spare_slot_d;
  logic [FrameBits-1:0] hit_age_q, hit_age_d;
  logic [RUN_BITS-1:0]  hit_run_q, hit_run_d;

  // result staging
  logic [RUN_BITS-1:0]  res_run_q, res_run_d, res_best_q, res_best_d;
  logic                 res_ovf_q, res_ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic [39:0]          out_data_q, out_data_d;
  logic [OutBits-1:0]   run_sat, best_sat;

  // table memory
  entry_t        mem [TABLE_ENTRIES];
  entry_t        rd_q, wr_data;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // home slot
  logic          home_go, home_done;
  logic [IW-1:0] home_res;
  assign home_go = (state_q == ST_HASH);

  frlt_home #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_home (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (home_go),
    .sum_i  (sum_q),
    .done_o (home_done),
    .home_o (home_res)
  );

  // probe address: home + issue, wrapped once
  logic [IW:0] slot_raw;
  always_comb begin
    slot_raw = {1'b0, home_q} + (IW+1)'(issue_q);
    if (slot_raw >= (IW+1)'(TABLE_ENTRIES)) begin
      slot_raw = slot_raw - (IW+1)'(TABLE_ENTRIES);
    end
  end

  // classify the entry that came back from memory
  logic                 ent_live, ent_match, ent_free;
  logic [FrameBits-1:0] ent_age;
  assign ent_live  = rd_q.valid && (rd_q.epoch == epoch_q);
  assign ent_match = ent_live && (rd_q.key == key_q);
  assign ent_age   = frame_q - rd_q.frame;
  assign ent_free  = !ent_live || (ent_age >= FrameBits'(2));

  // new run for the update step
  logic [RUN_BITS-1:0] run_new;
  logic                upd_ok;
  always_comb begin
    run_new = RUN_BITS'(1);
    upd_ok  = found_q || spare_q;
    if (found_q) begin
      if (hit_age_q == '0) begin
        run_new = hit_run_q;
      end else if (hit_age_q == FrameBits'(1)) begin
        run_new = (&hit_run_q) ? hit_run_q : hit_run_q + RUN_BITS'(1);
      end
    end
  end

  // output saturation to the 16-bit fields
  if (RUN_BITS > OutBits) begin : g_sat
    assign run_sat  = (|res_run_q[RUN_BITS-1:OutBits])  ? '1 : res_run_q[OutBits-1:0];
    assign best_sat = (|res_best_q[RUN_BITS-1:OutBits]) ? '1 : res_best_q[OutBits-1:0];
  end else begin : g_nosat
    assign run_sat  = OutBits'(res_run_q);
    assign best_sat = OutBits'(res_best_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == IW'(TABLE_ENTRIES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (cmd_e'(s_axis_tuser_i) == CMD_FEATURE) ? ST_HASH : ST_RESULT;
        end
      end
      ST_HASH: begin
        if (home_done) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (rd_pend_q && (ent_match || chk_q == PW'(PROBE_LIMIT - 1))) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_RESULT;
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready_i) state_d = clr_after_q ? ST_CLEAR : ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    frame_d      = frame_q;
    best_d       = best_q;
    epoch_d      = epoch_q;
    clr_after_d  = clr_after_q;
    clr_cnt_d    = clr_cnt_q;
    key_d        = key_q;
    sum_d        = sum_q;
    home_d       = home_q;
    issue_d      = issue_q;
    chk_d        = chk_q;
    rd_pend_d    = 1'b0;
    rd_slot_d    = rd_slot_q;
    found_d      = found_q;
    spare_d      = spare_q;
    hit_slot_d   = hit_slot_q;
    spare_slot_d = spare_slot_q;
    hit_age_d    = hit_age_q;
    hit_run_d    = hit_run_q;
    res_run_d    = res_run_q;
    res_best_d   = res_best_q;
    res_ovf_d    = res_ovf_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;
    rd_en        = 1'b0;
    rd_addr      = slot_raw[IW-1:0];
    wr_en        = 1'b0;
    wr_addr      = clr_cnt_q;
    wr_data      = '0;

    case (state_q)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        clr_cnt_d   = clr_cnt_q + IW'(1);
        clr_after_d = 1'b0;
      end
      ST_IDLE: begin
        if (in_acc) begin
          key_d      = s_axis_tdata_i[KeyBits-1:0];
          sum_d      = FrameBits'(s_axis_tdata_i[CoordBits-1:0])
                     + FrameBits'(s_axis_tdata_i[KeyBits-1:CoordBits]);
          res_run_d  = '0;
          res_best_d = best_q;
          res_ovf_d  = 1'b0;
          issue_d    = '0;
          found_d    = 1'b0;
          spare_d    = 1'b0;
          clr_cnt_d  = '0;
          case (cmd_e'(s_axis_tuser_i))
            CMD_EOF: frame_d = frame_q + FrameBits'(1);
            CMD_EOS: begin
              frame_d     = '0;
              best_d      = '0;
              epoch_d     = epoch_q + EpochBits'(1);
              clr_after_d = (epoch_d == '0);
            end
            default: ;
          endcase
        end
      end
      ST_HASH: begin
        home_d = home_res;
      end
      ST_PROBE: begin
        if (issue_q < PW'(PROBE_LIMIT)) begin
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          rd_slot_d = slot_raw[IW-1:0];
          chk_d     = issue_q;
          issue_d   = issue_q + PW'(1);
        end
        if (rd_pend_q) begin
          if (ent_match) begin
            found_d    = 1'b1;
            hit_slot_d = rd_slot_q;
            hit_age_d  = ent_age;
            hit_run_d  = rd_q.run;
          end else if (ent_free && !spare_q) begin
            spare_d      = 1'b1;
            spare_slot_d = rd_slot_q;
          end
        end
      end
      ST_UPDATE: begin
        if (upd_ok) begin
          wr_en         = 1'b1;
          wr_addr       = found_q ? hit_slot_q : spare_slot_q;
          wr_data.valid = 1'b1;
          wr_data.epoch = epoch_q;
          wr_data.key   = key_q;
          wr_data.frame = frame_q;
          wr_data.run   = run_new;
          best_d        = (run_new > best_q) ? run_new : best_q;
          res_run_d     = run_new;
          res_best_d    = (run_new > best_q) ? run_new : best_q;
          res_ovf_d     = 1'b0;
        end else begin
          res_run_d  = '0;
          res_best_d = best_q;
          res_ovf_d  = 1'b1;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, res_ovf_q, best_sat, run_sat};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      frame_q     <= '0;
      best_q      <= '0;
      epoch_q     <= '0;
      clr_after_q <= 1'b0;
      clr_cnt_q   <= '0;
      issue_q     <= '0;
      chk_q       <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      spare_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      best_q      <= best_d;
      epoch_q     <= epoch_d;
      clr_after_q <= clr_after_d;
      clr_cnt_q   <= clr_cnt_d;
      issue_q     <= issue_d;
      chk_q       <= chk_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      spare_q     <= spare_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    sum_q        <= sum_d;
    home_q       <= home_d;
    rd_slot_q    <= rd_slot_d;
    hit_slot_q   <= hit_slot_d;
    spare_slot_q <= spare_slot_d;
    hit_age_q    <= hit_age_d;
    hit_run_q    <= hit_run_d;
    res_run_q    <= res_run_d;
    res_best_q   <= res_best_d;
    res_ovf_q    <= res_ovf_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata_i[63:62];

endmodule
`default_nettype wire
